[design/tse_pkg.sv]
package tse_pkg;

    typedef enum logic [1:0] {
        KIND_PUSH  = 2'd0,
        KIND_OP    = 2'd1,
        KIND_PRINT = 2'd2,
        KIND_NOP   = 2'd3
    } tse_kind_t;

    typedef enum logic [3:0] {
        OP_NEG = 4'd0,
        OP_NOT = 4'd1,
        OP_SUB = 4'd2,
        OP_MUL = 4'd3,
        OP_ADD = 4'd4,
        OP_DIV = 4'd5,
        OP_MOD = 4'd6,
        OP_EQ  = 4'd7,
        OP_NE  = 4'd8,
        OP_LT  = 4'd9,
        OP_GT  = 4'd10,
        OP_LE  = 4'd11,
        OP_GE  = 4'd12,
        OP_AND = 4'd13,
        OP_OR  = 4'd14,
        OP_NOP = 4'd15
    } tse_op_t;

    typedef enum logic [2:0] {
        ST_PRINTED   = 3'd0,
        ST_UNDERFLOW = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_DIV_ZERO  = 3'd3,
        ST_MISMATCH  = 3'd4
    } tse_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RDB,
        S_RDA,
        S_EXEC,
        S_ITER,
        S_FIN,
        S_EMIT
    } tse_state_t;

    localparam logic [1:0] TAG_INT  = 2'd0;
    localparam logic [1:0] TAG_FIX  = 2'd1;
    localparam logic [1:0] TAG_BOOL = 2'd2;
    localparam logic [1:0] TAG_RSVD = 2'd3;

    localparam int FRAC_BITS = 16;
    localparam int IO_WIDTH  = 32;

endpackage

[design/tse_cmd_if.sv]
interface tse_cmd_if;
    import tse_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 kind;
    logic [1:0]                 value_tag;
    logic signed [IO_WIDTH-1:0] value;
    logic [3:0]                 operation;

    modport source (output valid, kind, value_tag, value, operation, input ready);
    modport sink (input valid, kind, value_tag, value, operation, output ready);
endinterface

[design/tse_res_if.sv]
interface tse_res_if;
    import tse_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [IO_WIDTH-1:0] out_value;
    logic [1:0]                 out_tag;
    logic [2:0]                 status;

    modport source (output valid, out_value, out_tag, status, input ready);
    modport sink (input valid, out_value, out_tag, status, output ready);
endinterface

[design/tse_ram.sv]
module tse_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[design/typed_stack_evaluator_core.sv]
// Channel | Role   | Payload                                | Moves when
// cmd     | sink   | kind, value_tag, value, operation      | cmd.valid && cmd.ready
// res     | source | out_value, out_tag, status             | res.valid && res.ready
//
// Sequence: a push is decoded and written; a print or an operation reads the top entry,
// and a binary operation the second, then executes; integer multiply, divide or modulo and
// fixed multiply or divide step one bit per cycle through the shared iterative adder.
// Reset clears the sequencer, the stack count and the result valid; stack RAM
// contents are not cleared. cmd.ready is high only in the idle state; a pending
// result waits in the output register while the next transaction is taken.
module typed_stack_evaluator_core
    import tse_pkg::*;
#(
    parameter int STACK_DEPTH = 16,
    parameter int VALUE_WIDTH = 32
) (
    input logic clk,
    input logic rst_n,
    tse_cmd_if.sink   cmd,
    tse_res_if.source res
);
    localparam int W  = VALUE_WIDTH;
    localparam int NW = VALUE_WIDTH + FRAC_BITS;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int KW = $clog2(NW + 1);
    localparam int EW = VALUE_WIDTH + 2;

    localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    // Saturate a magnitude to the signed range and apply the sign.
    function automatic logic [W-1:0] sat_mag(input logic over, input logic [W-1:0] m,
                                             input logic neg);
        logic [W-1:0] lim;
        lim = neg ? VMIN : VMAX;
        if (over || (m > lim))
        begin
            return lim;
        end
        return neg ? (~m + W'(1)) : m;
    endfunction

    function automatic logic [W-1:0] fix_addsub(input logic [W-1:0] a, input logic [W-1:0] b,
                                                input logic sub);
        logic [W-1:0] r;
        logic ovf;
        r = sub ? (a - b) : (a + b);
        if (sub)
        begin
            ovf = (a[W-1] != b[W-1]) && (r[W-1] != a[W-1]);
        end
        else
        begin
            ovf = (a[W-1] == b[W-1]) && (r[W-1] != a[W-1]);
        end
        if (ovf)
        begin
            return a[W-1] ? VMIN : VMAX;
        end
        return r;
    endfunction

    function automatic logic [W-1:0] magn(input logic [W-1:0] x);
        return x[W-1] ? (~x + W'(1)) : x;
    endfunction

    tse_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [1:0]    kind_reg, kind_next;
    logic [3:0]    op_reg, op_next;
    logic [1:0]    tag_in_reg, tag_in_next;
    logic [W-1:0]  val_in_reg, val_in_next;
    logic [W-1:0]  a_val_reg, a_val_next, b_val_reg, b_val_next;
    logic [1:0]    a_tag_reg, a_tag_next, b_tag_reg, b_tag_next;
    logic [W:0]    acc_reg, acc_next;
    logic [NW-1:0] lo_reg, lo_next;
    logic [W-1:0]  d_reg, d_next;
    logic [KW-1:0] iter_reg, iter_next;
    logic          div_reg, div_next;
    logic [W-1:0]  em_val_reg, em_val_next;
    logic [1:0]    em_tag_reg, em_tag_next;
    tse_status_t   em_st_reg, em_st_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [IO_WIDTH-1:0] out_value_reg, out_value_next;
    logic [1:0]                 out_tag_reg, out_tag_next;
    logic [2:0]                 status_reg, status_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;

    logic [CW-1:0] cnt_m1, cnt_m2;
    assign cnt_m1 = count_reg - CW'(1);
    assign cnt_m2 = count_reg - CW'(2);

    tse_ram #(.WIDTH(EW), .DEPTH(STACK_DEPTH)) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared adder of the multiply/divide unit.
    logic [W:0]   add_x, add_y;
    logic         add_cin;
    logic [W+1:0] add_sum;
    assign add_sum = {1'b0, add_x} + {1'b0, add_y} + (W+2)'(add_cin);

    always_comb
    begin
        if (div_reg)
        begin
            add_x   = {acc_reg[W-1:0], lo_reg[NW-1]};
            add_y   = ~{1'b0, d_reg};
            add_cin = 1'b1;
        end
        else
        begin
            add_x   = acc_reg;
            add_y   = lo_reg[0] ? {1'b0, d_reg} : '0;
            add_cin = 1'b0;
        end
    end

    // Operand evaluation: a is second from top, b is top.
    logic lt_ab, eq_ab, cmp_res;
    logic [2*W-1:0] full_prod;
    assign lt_ab     = $signed(a_val_reg) < $signed(b_val_reg);
    assign eq_ab     = a_val_reg == b_val_reg;
    assign full_prod = {acc_reg[W-1:0], lo_reg[W-1:0]};

    always_comb
    begin
        unique case (op_reg)
            OP_EQ:   cmp_res = eq_ab;
            OP_NE:   cmp_res = !eq_ab;
            OP_LT:   cmp_res = lt_ab;
            OP_GT:   cmp_res = !lt_ab && !eq_ab;
            OP_LE:   cmp_res = lt_ab || eq_ab;
            default: cmp_res = !lt_ab;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        kind_next      = kind_reg;
        op_next        = op_reg;
        tag_in_next    = tag_in_reg;
        val_in_next    = val_in_reg;
        a_val_next     = a_val_reg;
        a_tag_next     = a_tag_reg;
        b_val_next     = b_val_reg;
        b_tag_next     = b_tag_reg;
        acc_next       = acc_reg;
        lo_next        = lo_reg;
        d_next         = d_reg;
        iter_next      = iter_reg;
        div_next       = div_reg;
        em_val_next    = em_val_reg;
        em_tag_next    = em_tag_reg;
        em_st_next     = em_st_reg;
        out_valid_next = out_valid_reg & ~res.ready;
        out_value_next = out_value_reg;
        out_tag_next   = out_tag_reg;
        status_next    = status_reg;
        ram_we         = 1'b0;
        ram_waddr      = cnt_m1[AW-1:0];
        ram_wdata      = {a_tag_reg, a_val_reg};
        ram_raddr      = cnt_m1[AW-1:0];
        cmd.ready      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid)
                begin
                    kind_next   = cmd.kind;
                    op_next     = cmd.operation;
                    tag_in_next = cmd.value_tag;
                    val_in_next = W'(cmd.value);
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                em_val_next = '0;
                em_tag_next = TAG_INT;
                unique case (kind_reg)
                    KIND_PUSH:
                    begin
                        if (count_reg >= CW'(STACK_DEPTH))
                        begin
                            em_st_next = ST_OVERFLOW;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = count_reg[AW-1:0];
                            ram_wdata  = {tag_in_reg, val_in_reg};
                            count_next = count_reg + CW'(1);
                            state_next = S_IDLE;
                        end
                    end
                    KIND_PRINT:
                    begin
                        if (count_reg == '0)
                        begin
                            em_st_next = ST_UNDERFLOW;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_RDB;
                        end
                    end
                    KIND_OP:
                    begin
                        if (op_reg == OP_NOP)
                        begin
                            state_next = S_IDLE;
                        end
                        else if ((count_reg == '0) ||
                                 ((op_reg > OP_NOT) && (count_reg < CW'(2))))
                        begin
                            em_st_next = ST_UNDERFLOW;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_RDB;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_RDB:
            begin
                b_val_next = ram_rdata[W-1:0];
                b_tag_next = ram_rdata[EW-1:W];
                a_val_next = ram_rdata[W-1:0];
                a_tag_next = ram_rdata[EW-1:W];
                ram_raddr  = cnt_m2[AW-1:0];
                if ((kind_reg == KIND_OP) && (op_reg > OP_NOT))
                begin
                    state_next = S_RDA;
                end
                else
                begin
                    state_next = S_EXEC;
                end
            end
            S_RDA:
            begin
                a_val_next = ram_rdata[W-1:0];
                a_tag_next = ram_rdata[EW-1:W];
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                if (kind_reg == KIND_PRINT)
                begin
                    count_next  = cnt_m1;
                    em_val_next = b_val_reg;
                    em_tag_next = b_tag_reg;
                    em_st_next  = ST_PRINTED;
                    state_next  = S_EMIT;
                end
                else if (op_reg <= OP_NOT)
                begin
                    // Unary: rewrite the top entry in place.
                    ram_we    = 1'b1;
                    ram_waddr = cnt_m1[AW-1:0];
                    ram_wdata = {b_tag_reg, b_val_reg};
                    if (op_reg == OP_NEG)
                    begin
                        if (b_tag_reg == TAG_INT)
                        begin
                            ram_wdata[W-1:0] = ~b_val_reg + W'(1);
                        end
                        else if (b_tag_reg == TAG_FIX)
                        begin
                            ram_wdata[W-1:0] = fix_addsub('0, b_val_reg, 1'b1);
                        end
                    end
                    else if (b_tag_reg == TAG_BOOL)
                    begin
                        ram_wdata[W-1:0] = W'(b_val_reg == '0);
                    end
                end
                else if (a_tag_reg != b_tag_reg)
                begin
                    em_val_next = '0;
                    em_tag_next = TAG_INT;
                    em_st_next  = ST_MISMATCH;
                    state_next  = S_EMIT;
                end
                else
                begin
                    // Binary: result replaces a, default is a unchanged.
                    ram_waddr = cnt_m2[AW-1:0];
                    ram_wdata = {a_tag_reg, a_val_reg};
                    ram_we    = 1'b1;
                    count_next = cnt_m1;
                    unique case (op_reg)
                        OP_EQ, OP_NE, OP_LT, OP_GT, OP_LE, OP_GE:
                        begin
                            if (a_tag_reg <= TAG_FIX)
                            begin
                                ram_wdata = {TAG_BOOL, W'(cmp_res)};
                            end
                        end
                        OP_AND, OP_OR:
                        begin
                            if (a_tag_reg == TAG_BOOL)
                            begin
                                ram_wdata[W-1:0] = (op_reg == OP_AND) ?
                                    W'((a_val_reg != '0) && (b_val_reg != '0)) :
                                    W'((a_val_reg != '0) || (b_val_reg != '0));
                            end
                        end
                        OP_ADD, OP_SUB:
                        begin
                            if (a_tag_reg == TAG_INT)
                            begin
                                ram_wdata[W-1:0] = (op_reg == OP_SUB) ?
                                    (a_val_reg - b_val_reg) : (a_val_reg + b_val_reg);
                            end
                            else if (a_tag_reg == TAG_FIX)
                            begin
                                ram_wdata[W-1:0] = fix_addsub(a_val_reg, b_val_reg,
                                                              op_reg == OP_SUB);
                            end
                        end
                        OP_MUL, OP_DIV, OP_MOD:
                        begin
                            if ((a_tag_reg == TAG_INT) ||
                                ((a_tag_reg == TAG_FIX) && (op_reg != OP_MOD)))
                            begin
                                // Hold the write and start the iterative unit.
                                ram_we     = 1'b0;
                                count_next = count_reg;
                                acc_next   = '0;
                                iter_next  = '0;
                                div_next   = (op_reg != OP_MUL);
                                if (op_reg == OP_MUL)
                                begin
                                    if (a_tag_reg == TAG_INT)
                                    begin
                                        d_next  = a_val_reg;
                                        lo_next = NW'(b_val_reg);
                                    end
                                    else
                                    begin
                                        d_next  = magn(a_val_reg);
                                        lo_next = NW'(magn(b_val_reg));
                                    end
                                    state_next = S_ITER;
                                end
                                else if (b_val_reg == '0)
                                begin
                                    em_val_next = '0;
                                    em_tag_next = TAG_INT;
                                    em_st_next  = ST_DIV_ZERO;
                                    state_next  = S_EMIT;
                                end
                                else
                                begin
                                    d_next = magn(b_val_reg);
                                    if (a_tag_reg == TAG_INT)
                                    begin
                                        lo_next = NW'(magn(a_val_reg));
                                    end
                                    else
                                    begin
                                        lo_next = {magn(a_val_reg), {FRAC_BITS{1'b0}}};
                                    end
                                    state_next = S_ITER;
                                end
                            end
                        end
                        default: ram_we = 1'b1;
                    endcase
                end
            end
            S_ITER:
            begin
                // Advance one bit through the shared adder.
                if (div_reg)
                begin
                    acc_next = {1'b0, add_sum[W+1] ? add_sum[W-1:0] : add_x[W-1:0]};
                    lo_next  = {lo_reg[NW-2:0], add_sum[W+1]};
                end
                else
                begin
                    acc_next        = add_sum[W+1:1];
                    lo_next         = lo_reg >> 1;
                    lo_next[W-1]    = add_sum[0];
                end
                iter_next = iter_reg + KW'(1);
                if (iter_reg == (div_reg ? KW'(NW - 1) : KW'(W - 1)))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                ram_we     = 1'b1;
                ram_waddr  = cnt_m2[AW-1:0];
                count_next = cnt_m1;
                ram_wdata  = {a_tag_reg, a_val_reg};
                if (a_tag_reg == TAG_INT)
                begin
                    unique case (op_reg)
                        OP_MUL: ram_wdata[W-1:0] = lo_reg[W-1:0];
                        OP_DIV:
                        begin
                            ram_wdata[W-1:0] = (a_val_reg[W-1] ^ b_val_reg[W-1]) ?
                                (~lo_reg[W-1:0] + W'(1)) : lo_reg[W-1:0];
                        end
                        default:
                        begin
                            ram_wdata[W-1:0] = a_val_reg[W-1] ?
                                (~acc_reg[W-1:0] + W'(1)) : acc_reg[W-1:0];
                        end
                    endcase
                end
                else if (op_reg == OP_MUL)
                begin
                    ram_wdata[W-1:0] = sat_mag(|full_prod[2*W-1:W+FRAC_BITS],
                                               full_prod[W+FRAC_BITS-1:FRAC_BITS],
                                               a_val_reg[W-1] ^ b_val_reg[W-1]);
                end
                else
                begin
                    ram_wdata[W-1:0] = sat_mag(|lo_reg[NW-1:W], lo_reg[W-1:0],
                                               a_val_reg[W-1] ^ b_val_reg[W-1]);
                end
                state_next = S_IDLE;
            end
            S_EMIT:
            begin
                // Hold until the output register is free.
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = IO_WIDTH'(signed'(em_val_reg));
                    out_tag_next   = em_tag_reg;
                    status_next    = em_st_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        op_reg        <= op_next;
        tag_in_reg    <= tag_in_next;
        val_in_reg    <= val_in_next;
        a_val_reg     <= a_val_next;
        a_tag_reg     <= a_tag_next;
        b_val_reg     <= b_val_next;
        b_tag_reg     <= b_tag_next;
        acc_reg       <= acc_next;
        lo_reg        <= lo_next;
        d_reg         <= d_next;
        iter_reg      <= iter_next;
        div_reg       <= div_next;
        em_val_reg    <= em_val_next;
        em_tag_reg    <= em_tag_next;
        em_st_reg     <= em_st_next;
        out_value_reg <= out_value_next;
        out_tag_reg   <= out_tag_next;
        status_reg    <= status_next;
    end

    assign res.valid     = out_valid_reg;
    assign res.out_value = out_value_reg;
    assign res.out_tag   = out_tag_reg;
    assign res.status    = status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result raised outside emit state");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != ST_PRINTED)) |->
            ((out_value_reg == '0) && (out_tag_reg == TAG_INT)))
        else $error("error result carries data");

    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> (state_reg == S_DECODE))
        else $error("accepted transaction not decoded");
endmodule

[bench/typed_stack_evaluator_core_tb.sv]
module typed_stack_evaluator_core_tb;
    import tse_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  tag;
        tse_status_t status;
    } printout_t;

    // Tracks the evaluator stack and queues the printouts each command owes.
    class eval_scoreboard;
        logic [31:0] vals [16];
        logic [1:0]  tags [16];
        int          depth;
        printout_t   pending [$];
        int          errors;
        int          checked;

        function void clear();
            depth = 0;
            pending.delete();
            errors = 0;
            checked = 0;
        endfunction

        function void owe(logic [31:0] v, logic [1:0] t, tse_status_t s);
            printout_t p;
            p.value = v;
            p.tag = t;
            p.status = s;
            pending.push_back(p);
        endfunction

        // Saturate a sign and magnitude pair to the signed 32-bit range.
        function logic [31:0] clamp(logic [63:0] mag, bit neg);
            logic [63:0] lim;
            lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
            if (mag > lim)
                return neg ? 32'h8000_0000 : 32'h7fff_ffff;
            return neg ? -mag[31:0] : mag[31:0];
        endfunction

        function logic [31:0] fix_sum(logic [31:0] a, logic [31:0] b, bit sub);
            logic [31:0] r;
            bit ovf;
            r = sub ? a - b : a + b;
            ovf = sub ? (a[31] != b[31] && r[31] != a[31])
                      : (a[31] == b[31] && r[31] != a[31]);
            if (ovf)
                return a[31] ? 32'h8000_0000 : 32'h7fff_ffff;
            return r;
        endfunction

        function void note_command(logic [1:0] kind, logic [1:0] vtag,
                                   logic [31:0] value, logic [3:0] op);
            logic [31:0] a, b, r, ma, mb;
            logic [1:0]  tg, rt;
            logic [63:0] wide;
            bit          lt, eq, res, neg;
            if (kind == KIND_PUSH)
            begin
                if (depth >= 16)
                    owe(0, 0, ST_OVERFLOW);
                else
                begin
                    vals[depth] = value;
                    tags[depth] = vtag;
                    depth++;
                end
                return;
            end
            if (kind == KIND_PRINT)
            begin
                if (depth == 0)
                    owe(0, 0, ST_UNDERFLOW);
                else
                begin
                    depth--;
                    owe(vals[depth], tags[depth], ST_PRINTED);
                end
                return;
            end
            if (kind != KIND_OP || op > OP_OR)
                return;
            if (op == OP_NEG || op == OP_NOT)
            begin
                if (depth < 1)
                begin
                    owe(0, 0, ST_UNDERFLOW);
                    return;
                end
                a = vals[depth-1];
                tg = tags[depth-1];
                if (op == OP_NEG && tg == TAG_INT)
                    vals[depth-1] = -a;
                else if (op == OP_NEG && tg == TAG_FIX)
                    vals[depth-1] = fix_sum(0, a, 1);
                else if (op == OP_NOT && tg == TAG_BOOL)
                    vals[depth-1] = (a == 0) ? 1 : 0;
                return;
            end
            if (depth < 2)
            begin
                owe(0, 0, ST_UNDERFLOW);
                return;
            end
            a = vals[depth-2];
            b = vals[depth-1];
            tg = tags[depth-2];
            if (tg != tags[depth-1])
            begin
                owe(0, 0, ST_MISMATCH);
                return;
            end
            r = a;
            rt = tg;
            ma = a[31] ? -a : a;
            mb = b[31] ? -b : b;
            neg = a[31] != b[31];
            if (op >= OP_EQ && op <= OP_GE)
            begin
                if (tg == TAG_INT || tg == TAG_FIX)
                begin
                    lt = $signed(a) < $signed(b);
                    eq = a == b;
                    case (op)
                        OP_EQ: res = eq;
                        OP_NE: res = !eq;
                        OP_LT: res = lt;
                        OP_GT: res = !lt && !eq;
                        OP_LE: res = lt || eq;
                        default: res = !lt;
                    endcase
                    r = res;
                    rt = TAG_BOOL;
                end
            end
            else if (op == OP_AND || op == OP_OR)
            begin
                if (tg == TAG_BOOL)
                    r = (op == OP_AND) ? (a != 0 && b != 0) : (a != 0 || b != 0);
            end
            else if (tg == TAG_INT)
            begin
                case (op)
                    OP_SUB: r = a - b;
                    OP_MUL: r = a * b;
                    OP_ADD: r = a + b;
                    default:
                    begin
                        if (mb == 0)
                        begin
                            owe(0, 0, ST_DIV_ZERO);
                            return;
                        end
                        if (op == OP_DIV)
                            r = neg ? -(ma / mb) : ma / mb;
                        else
                            r = a[31] ? -(ma % mb) : ma % mb;
                    end
                endcase
            end
            else if (tg == TAG_FIX)
            begin
                if (op == OP_SUB || op == OP_ADD)
                    r = fix_sum(a, b, op == OP_SUB);
                else if (op == OP_MUL)
                begin
                    wide = (64'(ma) * 64'(mb)) >> FRAC_BITS;
                    r = clamp(wide, neg);
                end
                else if (op == OP_DIV)
                begin
                    if (mb == 0)
                    begin
                        owe(0, 0, ST_DIV_ZERO);
                        return;
                    end
                    wide = (64'(ma) << FRAC_BITS) / 64'(mb);
                    r = clamp(wide, neg);
                end
            end
            depth--;
            vals[depth-1] = r;
            tags[depth-1] = rt;
        endfunction

        function void check_result(logic [31:0] v, logic [1:0] t, logic [2:0] s);
            printout_t p;
            checked++;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result value=%h tag=%0d status=%0d",
                         $time, v, t, s);
                errors++;
                return;
            end
            p = pending.pop_front();
            if (v !== p.value || t !== p.tag || s !== p.status)
            begin
                $display("%0t: mismatch expected value=%h tag=%0d status=%0d,",
                         $time, p.value, p.tag, p.status);
                $display("%0t:          got value=%h tag=%0d status=%0d",
                         $time, v, t, s);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    tse_cmd_if cmd_ch();
    tse_res_if res_ch();

    typed_stack_evaluator_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    eval_scoreboard board;

    // Idle and stall odds in percent, changed per phase.
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;
    int n_push, n_op, n_print, n_other;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Randomly stall the result channel; sample the handshake with pre-edge values.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            if (res_ch.valid && res_ch.ready)
                board.check_result(res_ch.out_value, res_ch.out_tag, res_ch.status);
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: count cycles with no transaction on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 3000)
        begin
            $display("typed_stack_evaluator_core_tb: FAIL");
            $finish;
        end
    end

    // Offer one command and hold it until the transaction completes.
    // Valid stays high across back-to-back commands; drop it only on idle cycles.
    task automatic send(logic [1:0] kind, logic [1:0] vtag, logic [31:0] value,
                        logic [3:0] op);
        if ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.kind      <= kind;
        cmd_ch.value_tag <= vtag;
        cmd_ch.value     <= value;
        cmd_ch.operation <= op;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        board.note_command(kind, vtag, value, op);
        case (kind)
            KIND_PUSH:  n_push++;
            KIND_OP:    n_op++;
            KIND_PRINT: n_print++;
            default:    n_other++;
        endcase
    endtask

    task automatic push(logic [1:0] vtag, logic [31:0] value);
        send(KIND_PUSH, vtag, value, OP_NEG);
    endtask

    task automatic apply(tse_op_t op);
        send(KIND_OP, TAG_INT, $urandom, op);
    endtask

    task automatic show();
        send(KIND_PRINT, TAG_INT, $urandom, OP_NEG);
    endtask

    function automatic logic [31:0] pick_value(logic [1:0] vtag);
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 0;
            3: return $urandom_range(1) ? 32'hffff_ffff : 32'h1;
            4, 5: return (vtag == TAG_BOOL) ? 32'($urandom_range(1))
                                            : 32'($signed($urandom_range(40)) - 20);
            6: return (vtag == TAG_FIX) ? 32'($signed($urandom_range(8)) - 4) << FRAC_BITS
                                        : $urandom;
            default: return $urandom;
        endcase
    endfunction

    // One random command, biased toward well-formed sequences on matching tags.
    task automatic random_command();
        logic [1:0] vtag;
        int roll;
        roll = $urandom_range(99);
        vtag = (board.depth > 0 && $urandom_range(99) < 85) ? board.tags[board.depth-1]
                                                              : 2'($urandom_range(2));
        if ($urandom_range(99) < 2)
            vtag = TAG_RSVD;
        if (roll < 4)
            send(KIND_NOP, 2'($urandom), $urandom, 4'($urandom));
        else if (roll < 7)
            send(KIND_OP, 2'($urandom), $urandom, OP_NOP);
        else if (roll < 45 && (board.depth < 12 || roll < 9))
            push(vtag, pick_value(vtag));
        else if (roll < 82)
            apply(tse_op_t'($urandom_range(14)));
        else
            show();
    endtask

    initial
    begin
        board = new();
        board.clear();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        n_push = 0;
        n_op = 0;
        n_print = 0;
        n_other = 0;
        rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.kind = KIND_PUSH;
        cmd_ch.value_tag = TAG_INT;
        cmd_ch.value = 0;
        cmd_ch.operation = OP_NEG;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: wraparound divide, fixed saturation, errors, pass-through cases.
        push(TAG_INT, 32'h8000_0000);
        push(TAG_INT, 32'hffff_ffff);
        apply(OP_DIV);
        show();
        push(TAG_FIX, 32'h7fff_ffff);
        push(TAG_FIX, 32'h7fff_ffff);
        apply(OP_MUL);
        show();
        push(TAG_INT, 5);
        push(TAG_FIX, 5);
        apply(OP_ADD);
        show();
        show();
        show();
        apply(OP_NEG);
        push(TAG_INT, 7);
        apply(OP_SUB);
        push(TAG_INT, 0);
        apply(OP_MOD);
        apply(OP_EQ);
        apply(OP_NOT);
        show();
        push(TAG_FIX, 32'h8000_0000);
        push(TAG_FIX, 0);
        apply(OP_MOD);
        apply(OP_DIV);
        apply(OP_NEG);
        show();
        push(TAG_RSVD, 32'hdead_beef);
        push(TAG_RSVD, 32'h1234_5678);
        send(KIND_OP, TAG_INT, 0, OP_NOP);
        send(KIND_NOP, TAG_RSVD, 32'hffff_ffff, OP_NOP);
        apply(OP_OR);
        show();
        // Fill past the top to hit overflow, then drain.
        repeat (17) push(TAG_BOOL, 32'($urandom_range(1)));
        apply(OP_AND);
        apply(OP_OR);
        repeat (16) show();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 73;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 73;
                end
                default:
                begin
                    send_idle_pct = 17;
                    recv_stall_pct = 17;
                end
            endcase
            repeat (95) random_command();
        end

        cmd_ch.valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        $display("Covered %0d pushes, %0d operations, %0d prints, %0d ignored commands;",
                 n_push, n_op, n_print, n_other);
        $display("%0d results checked over four handshake pacing phases.", board.checked);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("typed_stack_evaluator_core_tb: PASS");
        else
            $display("typed_stack_evaluator_core_tb: FAIL");
        $finish;
    end

endmodule
